[src/lorentz_boost_top_assert.svh]
// Assertion macros for the Lorentz boost top level.
`ifndef LORENTZ_BOOST_TOP_ASSERT_SVH
`define LORENTZ_BOOST_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LB_AP_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LB_AP_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/lb_pkg.sv]
// Shared widths, types, status codes and pipeline stage map for the Lorentz boost.
`timescale 1ns / 1ps

package lb_pkg;

  localparam int MOM_W  = 48;
  localparam int BETA_W = 32;

  typedef logic signed [MOM_W-1:0]  mom_t;
  typedef logic signed [BETA_W-1:0] beta_t;
  typedef logic signed [63:0]       wide_t;

  typedef enum logic [1:0] {
    STAT_BOOST = 2'd0,
    STAT_PASS  = 2'd1,
    STAT_LIGHT = 2'd2
  } status_t;

  localparam logic [63:0] ONE_B2 = 64'h1000_0000_0000_0000;
  localparam wide_t       SMAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam wide_t       MOM_HI = (64'sd1 <<< (MOM_W - 1)) - 64'sd1;
  localparam wide_t       MOM_LO = -MOM_HI - 64'sd1;

  // multiplier: magnitude, partial products, sum, saturate
  localparam int MUL_LAT = 4;

  // gamma unit
  localparam int NORM_STG = 5;
  localparam int SQ_PER   = 2;
  localparam int SQ_STG   = 32 / SQ_PER;
  localparam int D_PER    = 3;
  localparam int D1_ITER  = 90;
  localparam int D1_STG   = D1_ITER / D_PER;
  localparam int D2_ITER  = 60;
  localparam int D2_STG   = D2_ITER / D_PER;
  localparam int GAM_LAT  = 1 + NORM_STG + SQ_STG + 1 + D1_STG + 1 + D2_STG + 1;

  // main pipeline stage map
  localparam int PS_IN   = 1;
  localparam int PS_B2   = 3;
  localparam int PS_OVER = PS_B2 + 1;
  localparam int PS_S    = PS_IN + MUL_LAT + 1;
  localparam int PS_T    = PS_S + 1;
  localparam int PS_GW   = PS_B2 + GAM_LAT + 1;
  localparam int PS_KW   = PS_GW + MUL_LAT;
  localparam int PS_CW   = PS_KW + MUL_LAT + 1;
  localparam int PS_LAST = PS_CW + MUL_LAT;

endpackage

[src/lb_if.sv]
// Valid/ready channel interfaces for the boost input and result beats.
`timescale 1ns / 1ps

interface lb_in_if import lb_pkg::*; ();
  logic  valid;
  logic  ready;
  mom_t  mom_x;
  mom_t  mom_y;
  mom_t  mom_z;
  mom_t  total_energy;
  beta_t beta_x;
  beta_t beta_y;
  beta_t beta_z;

  modport source (output valid, output mom_x, output mom_y, output mom_z,
                  output total_energy, output beta_x, output beta_y, output beta_z,
                  input ready);
  modport sink (input valid, input mom_x, input mom_y, input mom_z,
                input total_energy, input beta_x, input beta_y, input beta_z,
                output ready);
endinterface

interface lb_out_if import lb_pkg::*; ();
  logic    valid;
  logic    ready;
  mom_t    out_x;
  mom_t    out_y;
  mom_t    out_z;
  mom_t    out_energy;
  status_t status;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output out_energy, output status, input ready);
  modport sink (input valid, input out_x, input out_y, input out_z,
                input out_energy, input status, output ready);
endinterface

[src/lb_mul.sv]
// Pipelined signed 64x64 multiply, shifted right by 30, magnitude saturated.
`timescale 1ns / 1ps

module lb_mul import lb_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  wide_t a,
  input  wide_t b,
  output wide_t p
);

  logic [63:0]  ma_r, mb_r;
  logic         ng1_r, ng2_r, ng3_r;
  logic [63:0]  p00_r, p01_r, p10_r, p11_r;
  logic [127:0] pr_r;
  wide_t        p_r;
  wide_t        p_nxt;
  wide_t        mag;

  always_comb begin
    // anything at or above bit 93 pushes the shifted magnitude past 2^63-1
    if (|pr_r[127:93]) begin
      mag = SMAX;
    end else begin
      mag = {1'b0, pr_r[92:30]};
    end
    p_nxt = ng3_r ? -mag : mag;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r  <= a[63] ? -a : a;
      mb_r  <= b[63] ? -b : b;
      ng1_r <= a[63] ^ b[63];
      p00_r <= ma_r[31:0]  * mb_r[31:0];
      p01_r <= ma_r[31:0]  * mb_r[63:32];
      p10_r <= ma_r[63:32] * mb_r[31:0];
      p11_r <= ma_r[63:32] * mb_r[63:32];
      ng2_r <= ng1_r;
      pr_r  <= {64'd0, p00_r} + ({64'd0, p01_r} << 32) + ({64'd0, p10_r} << 32)
               + {p11_r, 64'd0};
      ng3_r <= ng2_r;
      p_r   <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

[src/lb_gamma.sv]
// Gamma unit: normalize 1-b2, square root, then gamma and 1-1/(1+gamma) by long division.
`timescale 1ns / 1ps

module lb_gamma import lb_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] b2,
  output logic [60:0] g,
  output logic [30:0] f
);

  typedef struct packed {
    logic [61:0] x;
    logic [4:0]  m;
  } nrm_t;

  typedef struct packed {
    logic [34:0] rem;
    logic [31:0] root;
    logic [63:0] xs;
    logic [4:0]  m;
  } sqs_t;

  typedef struct packed {
    logic [61:0] rem;
    logic [60:0] q;
    logic [60:0] dv;
  } dv1_t;

  typedef struct packed {
    logic [62:0] rem;
    logic [30:0] q;
    logic [61:0] dv;
    logic [60:0] g;
  } dv2_t;

  // shift by 2*s while the word stays below 2^62; s = 16, 8, 4, 2, 1
  function automatic nrm_t nrm_step(nrm_t a, int j);
    nrm_t r;
    int   s;
    r = a;
    s = 16 >> j;
    if (r.x < (62'd1 << (62 - 2 * s))) begin
      r.x = r.x << (2 * s);
      r.m = r.m + 5'(s);
    end
    return r;
  endfunction

  function automatic sqs_t sq_step(sqs_t a);
    sqs_t        r;
    logic [33:0] trial;
    r = a;
    for (int i = 0; i < SQ_PER; i++) begin
      r.rem = {r.rem[32:0], r.xs[63:62]};
      r.xs  = {r.xs[61:0], 2'b00};
      trial = {r.root, 2'b01};
      if (r.rem >= {1'b0, trial}) begin
        r.rem  = r.rem - {1'b0, trial};
        r.root = {r.root[30:0], 1'b1};
      end else begin
        r.root = {r.root[30:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic dv1_t dv1_step(dv1_t a);
    dv1_t r;
    r = a;
    for (int i = 0; i < D_PER; i++) begin
      r.rem = {r.rem[60:0], 1'b0};
      r.q   = {r.q[59:0], 1'b0};
      if (r.rem >= {1'b0, r.dv}) begin
        r.rem  = r.rem - {1'b0, r.dv};
        r.q[0] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic dv2_t dv2_step(dv2_t a);
    dv2_t r;
    r = a;
    for (int i = 0; i < D_PER; i++) begin
      r.rem = {r.rem[61:0], 1'b0};
      r.q   = {r.q[29:0], 1'b0};
      if (r.rem >= {1'b0, r.dv}) begin
        r.rem  = r.rem - {1'b0, r.dv};
        r.q[0] = 1'b1;
      end
    end
    return r;
  endfunction

  logic [60:0] d_r, d_nxt;
  nrm_t        nrm_r   [NORM_STG];
  nrm_t        nrm_nxt [NORM_STG];
  sqs_t        sqs_r   [SQ_STG];
  sqs_t        sqs_nxt [SQ_STG];
  logic [60:0] dv_r, dv_nxt;
  dv1_t        d1_r    [D1_STG];
  dv1_t        d1_nxt  [D1_STG];
  logic [61:0] e_r, e_nxt;
  logic [60:0] ge_r, ge_nxt;
  dv2_t        d2_r    [D2_STG];
  dv2_t        d2_nxt  [D2_STG];
  logic [60:0] g_r, g_nxt;
  logic [30:0] f_r, f_nxt;

  always_comb begin
    nrm_t n0;
    sqs_t s0;
    dv1_t a1;
    dv2_t a2;

    // over light speed is flagged elsewhere; keep the datapath defined
    d_nxt = (b2 >= ONE_B2) ? 61'(ONE_B2) : 61'(ONE_B2 - b2);

    n0.x = {1'b0, d_r};
    n0.m = '0;
    nrm_nxt[0] = nrm_step(n0, 0);
    for (int j = 1; j < NORM_STG; j++) begin
      nrm_nxt[j] = nrm_step(nrm_r[j-1], j);
    end

    s0.rem  = '0;
    s0.root = '0;
    s0.xs   = {2'b00, nrm_r[NORM_STG-1].x};
    s0.m    = nrm_r[NORM_STG-1].m;
    sqs_nxt[0] = sq_step(s0);
    for (int j = 1; j < SQ_STG; j++) begin
      sqs_nxt[j] = sq_step(sqs_r[j-1]);
    end

    // 2^(60+m)/r == 2^90/(r << (30-m))
    dv_nxt = 61'(sqs_r[SQ_STG-1].root[30:0]) << (5'd30 - sqs_r[SQ_STG-1].m);

    a1.rem = 62'd1;
    a1.q   = '0;
    a1.dv  = dv_r;
    d1_nxt[0] = dv1_step(a1);
    for (int j = 1; j < D1_STG; j++) begin
      d1_nxt[j] = dv1_step(d1_r[j-1]);
    end

    e_nxt  = {1'b0, d1_r[D1_STG-1].q} + (62'd1 << 30);
    ge_nxt = d1_r[D1_STG-1].q;

    a2.rem = 63'd1;
    a2.q   = '0;
    a2.dv  = e_r;
    a2.g   = ge_r;
    d2_nxt[0] = dv2_step(a2);
    for (int j = 1; j < D2_STG; j++) begin
      d2_nxt[j] = dv2_step(d2_r[j-1]);
    end

    f_nxt = (31'd1 << 30) - d2_r[D2_STG-1].q;
    g_nxt = d2_r[D2_STG-1].g;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r   <= d_nxt;
      nrm_r <= nrm_nxt;
      sqs_r <= sqs_nxt;
      dv_r  <= dv_nxt;
      d1_r  <= d1_nxt;
      e_r   <= e_nxt;
      ge_r  <= ge_nxt;
      d2_r  <= d2_nxt;
      g_r   <= g_nxt;
      f_r   <= f_nxt;
    end
  end

  assign g = g_r;
  assign f = f_r;

endmodule

[src/lorentz_boost_top.sv]
// Lorentz boost of one four-momentum per beat, fully pipelined.
// Throughput: one beat per cycle; a stall on the result side freezes every stage.
// Depth is set by the gamma chain: 32-step square root and 90- and 60-step divisions.
// Reset (rst_n low, synchronous) clears the stage valid bits and the output valid;
// datapath registers are not reset.
`timescale 1ns / 1ps
`include "lorentz_boost_top_assert.svh"

module lorentz_boost_top import lb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  lb_in_if.sink    in_ch,
  lb_out_if.source out_ch
);

  typedef struct packed {
    mom_t  [3:0] p;
    beta_t [2:0] b;
    logic        over;
    wide_t       s;
    wide_t       t;
    wide_t       g;
    wide_t       k;
    wide_t       c;
    wide_t       e;
  } side_t;

  function automatic wide_t mw(mom_t v);
    return {{(64-MOM_W){v[MOM_W-1]}}, v};
  endfunction

  function automatic wide_t bw(beta_t v);
    return {{(64-BETA_W){v[BETA_W-1]}}, v};
  endfunction

  function automatic wide_t sat_add(wide_t a, wide_t b);
    logic signed [64:0] s;
    s = $signed({a[63], a}) + $signed({b[63], b});
    if (s > $signed({1'b0, SMAX})) begin
      return SMAX;
    end else if (s < -$signed({1'b0, SMAX})) begin
      return -SMAX;
    end
    return s[63:0];
  endfunction

  function automatic mom_t clamp(wide_t v);
    if (v > MOM_HI) begin
      return MOM_HI[MOM_W-1:0];
    end else if (v < MOM_LO) begin
      return MOM_LO[MOM_W-1:0];
    end
    return v[MOM_W-1:0];
  endfunction

  logic               adv;
  logic [PS_LAST:1]   vld_r;
  side_t              pipe_r   [1:PS_LAST];
  side_t              pipe_nxt [1:PS_LAST];
  logic [63:0]        sq_r     [3];
  logic [63:0]        sq_nxt   [3];
  logic [63:0]        b2_r, b2_nxt;
  logic [60:0]        g_out;
  logic [30:0]        f_out;
  wide_t              sp_out   [3];
  wide_t              bo_out   [3];
  wide_t              k_out, c1_out, c2_out, e_out;

  logic               out_valid_r;
  mom_t               ox_r, oy_r, oz_r, oe_r;
  mom_t               ox_nxt, oy_nxt, oz_nxt, oe_nxt;
  status_t            st_r, st_nxt;

  // the output register parts the two sides; every stage moves together
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  always_comb begin
    logic signed [63:0] sq;
    pipe_nxt[1]      = '0;
    pipe_nxt[1].p[0] = in_ch.mom_x;
    pipe_nxt[1].p[1] = in_ch.mom_y;
    pipe_nxt[1].p[2] = in_ch.mom_z;
    pipe_nxt[1].p[3] = in_ch.total_energy;
    pipe_nxt[1].b[0] = in_ch.beta_x;
    pipe_nxt[1].b[1] = in_ch.beta_y;
    pipe_nxt[1].b[2] = in_ch.beta_z;
    for (int j = 2; j <= PS_LAST; j++) begin
      pipe_nxt[j] = pipe_r[j-1];
    end

    for (int i = 0; i < 3; i++) begin
      sq        = $signed(pipe_r[PS_IN].b[i]) * $signed(pipe_r[PS_IN].b[i]);
      sq_nxt[i] = sq;
    end
    b2_nxt = sq_r[0] + sq_r[1] + sq_r[2];

    pipe_nxt[PS_OVER].over = (b2_r >= ONE_B2);
    pipe_nxt[PS_S].s  = sat_add(sat_add(sp_out[0], sp_out[1]), sp_out[2]);
    pipe_nxt[PS_T].t  = sat_add(mw(pipe_r[PS_T-1].p[3]), pipe_r[PS_T-1].s);
    pipe_nxt[PS_GW].g = {3'b000, g_out};
    pipe_nxt[PS_KW].k = k_out;
    pipe_nxt[PS_CW].c = sat_add(c1_out, c2_out);
    pipe_nxt[PS_CW].e = e_out;
  end

  lb_gamma u_gamma (
    .clk (clk),
    .en  (adv),
    .b2  (b2_r),
    .g   (g_out),
    .f   (f_out)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    lb_mul u_sp (
      .clk (clk),
      .en  (adv),
      .a   (bw(pipe_r[PS_IN].b[i])),
      .b   (mw(pipe_r[PS_IN].p[i])),
      .p   (sp_out[i])
    );

    lb_mul u_bo (
      .clk (clk),
      .en  (adv),
      .a   (bw(pipe_r[PS_CW].b[i])),
      .b   (pipe_r[PS_CW].c),
      .p   (bo_out[i])
    );
  end

  lb_mul u_k (
    .clk (clk),
    .en  (adv),
    .a   ({3'b000, g_out}),
    .b   ({33'd0, f_out}),
    .p   (k_out)
  );

  lb_mul u_c1 (
    .clk (clk),
    .en  (adv),
    .a   (pipe_r[PS_KW].k),
    .b   (pipe_r[PS_KW].s),
    .p   (c1_out)
  );

  lb_mul u_c2 (
    .clk (clk),
    .en  (adv),
    .a   (pipe_r[PS_KW].g),
    .b   (mw(pipe_r[PS_KW].p[3])),
    .p   (c2_out)
  );

  lb_mul u_e (
    .clk (clk),
    .en  (adv),
    .a   (pipe_r[PS_KW].g),
    .b   (pipe_r[PS_KW].t),
    .p   (e_out)
  );

  always_comb begin
    logic zero_b;
    zero_b = (pipe_r[PS_LAST].b[0] == '0) && (pipe_r[PS_LAST].b[1] == '0)
             && (pipe_r[PS_LAST].b[2] == '0);
    if (zero_b) begin
      ox_nxt = pipe_r[PS_LAST].p[0];
      oy_nxt = pipe_r[PS_LAST].p[1];
      oz_nxt = pipe_r[PS_LAST].p[2];
      oe_nxt = pipe_r[PS_LAST].p[3];
      st_nxt = STAT_PASS;
    end else if (pipe_r[PS_LAST].over) begin
      ox_nxt = '0;
      oy_nxt = '0;
      oz_nxt = '0;
      oe_nxt = '0;
      st_nxt = STAT_LIGHT;
    end else begin
      ox_nxt = clamp(sat_add(mw(pipe_r[PS_LAST].p[0]), bo_out[0]));
      oy_nxt = clamp(sat_add(mw(pipe_r[PS_LAST].p[1]), bo_out[1]));
      oz_nxt = clamp(sat_add(mw(pipe_r[PS_LAST].p[2]), bo_out[2]));
      oe_nxt = clamp(pipe_r[PS_LAST].e);
      st_nxt = STAT_BOOST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[PS_LAST-1:1], in_ch.valid};
      out_valid_r <= vld_r[PS_LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe_r <= pipe_nxt;
      sq_r   <= sq_nxt;
      b2_r   <= b2_nxt;
      ox_r   <= ox_nxt;
      oy_r   <= oy_nxt;
      oz_r   <= oz_nxt;
      oe_r   <= oe_nxt;
      st_r   <= st_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_x      = ox_r;
  assign out_ch.out_y      = oy_r;
  assign out_ch.out_z      = oz_r;
  assign out_ch.out_energy = oe_r;
  assign out_ch.status     = st_r;

  `LB_AP_NOW(a_light_zero, out_ch.valid && out_ch.status == STAT_LIGHT, out_ch.out_x == '0 && out_ch.out_y == '0 && out_ch.out_z == '0 && out_ch.out_energy == '0, "light-speed beat with nonzero momentum")
  `LB_AP_NOW(a_ready_free, !out_ch.valid, in_ch.ready, "input held off with empty output register")
  `LB_AP_NEXT(a_stall_freeze, out_ch.valid && !out_ch.ready, $stable(vld_r), "pipeline moved during a stall")

endmodule
